@@ src/greedy_word_wrap_text_layout_macros.svh @@
`ifndef GREEDY_WORD_WRAP_TEXT_LAYOUT_MACROS_SVH
`define GREEDY_WORD_WRAP_TEXT_LAYOUT_MACROS_SVH

// check cons in the cycle after ante, outside reset
`define GWW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check cons in the same cycle as ante, reset included
`define GWW_ASSERT_NOW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/gww_pkg.sv @@
package gww_pkg;

    localparam int MAX_WORD_DEF = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam logic [7:0]  RST_CHAR_ADVANCE = 8'd6;
    localparam logic [7:0]  RST_CHAR_GAP     = 8'd1;
    localparam logic [7:0]  RST_LINE_ADVANCE = 8'd7;
    localparam logic [11:0] RST_LINE_WIDTH   = 12'd224;

    typedef enum logic [1:0] {
        REG_CHAR_ADVANCE,
        REG_CHAR_GAP,
        REG_LINE_ADVANCE,
        REG_LINE_WIDTH
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_SPACE,
        SEP_NEWLINE
    } sep_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TEST,
        BK_SEND
    } back_state_t;

    typedef struct packed {
        logic [7:0]  char_advance;
        logic [7:0]  char_gap;
        logic [7:0]  line_advance;
        logic [11:0] line_width;
    } gww_cfg_t;

    typedef struct packed {
        logic        restart;
        logic        has_glyph;
        logic [7:0]  code;
        logic        flush;
        sep_t        sep;
        logic [15:0] pixels;
    } gww_entry_t;

endpackage

@@ src/greedy_word_wrap_text_layout.sv @@
// Greedy word-wrap layout: characters go in through a push/full port, glyph placements
// (code, x, y, last_of_run) come out through an empty/pop port. The front takes one
// character per cycle while its four-entry command queue has room. The back takes each
// character from the queue, storing a glyph in the word memory, and for every space,
// newline, end of text or full word runs the line-break test and then places the
// buffered glyphs one at a time through the word memory's single read port, holding while
// a placement waits to be popped; it takes no new character until the word is placed.
// last_of_run marks the final placement that a character caused; a separator with no
// buffered word places nothing. Positions wrap modulo 65536. Configuration writes take
// effect at once and are meant for idle time.
module greedy_word_wrap_text_layout #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gww_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_text,
    input  logic                            restart,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      glyph_code,
    output logic [15:0]                     pos_x,
    output logic [15:0]                     pos_y,
    output logic                            last_of_run
);
    import gww_pkg::*;

    gww_cfg_t   cfg_reg;
    logic       q_push, q_pop, q_full, q_empty;
    gww_entry_t q_wr_entry, q_rd_entry;

    assign full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_advance <= RST_CHAR_ADVANCE;
            cfg_reg.char_gap     <= RST_CHAR_GAP;
            cfg_reg.line_advance <= RST_LINE_ADVANCE;
            cfg_reg.line_width   <= RST_LINE_WIDTH;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CHAR_ADVANCE: cfg_reg.char_advance <= cfg_data[7:0];
                REG_CHAR_GAP:     cfg_reg.char_gap     <= cfg_data[7:0];
                REG_LINE_ADVANCE: cfg_reg.line_advance <= cfg_data[7:0];
                REG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_data[11:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    gww_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .restart     (restart),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_wr_entry)
    );

    gww_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop_en   (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    gww_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_entry     (q_rd_entry),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .glyph_code  (glyph_code),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .last_of_run (last_of_run)
    );

endmodule

@@ src/gww_queue.sv @@
module gww_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  gww_pkg::gww_entry_t wr_entry,
    output logic                full,
    input  logic                pop_en,
    output gww_pkg::gww_entry_t rd_entry,
    output logic                empty
);
    import gww_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    gww_entry_t       entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push_en && !full;
    assign do_pop   = pop_en && !empty;
    assign rd_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ src/gww_front.sv @@
module gww_front #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    input  logic                restart,
    input  gww_pkg::gww_cfg_t   cfg,
    input  logic                q_full,
    output logic                q_push,
    output gww_pkg::gww_entry_t q_entry
);
    import gww_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);

    logic [LW-1:0] len_reg, len_next;
    logic [15:0]   pix_reg, pix_next;
    logic [LW-1:0] len_eff, len_new;
    logic [15:0]   pix_eff, pix_new;
    logic          is_sep;
    logic          flush_word;

    assign q_push = push && !q_full;

    always_comb
    begin
        len_eff    = restart ? '0 : len_reg;
        pix_eff    = restart ? '0 : pix_reg;
        is_sep     = (text_byte == CH_SPACE) || (text_byte == CH_NEWLINE);
        pix_new    = pix_eff + ((len_eff != '0) ? {8'd0, cfg.char_gap} : 16'd0)
                     + {8'd0, cfg.char_advance};
        len_new    = len_eff + LW'(1);
        flush_word = (len_new == LW'(MAX_WORD)) || end_of_text;

        q_entry.restart   = restart;
        q_entry.code      = text_byte;
        len_next          = len_reg;
        pix_next          = pix_reg;

        if (is_sep)
        begin
            q_entry.has_glyph = 1'b0;
            q_entry.flush     = 1'b1;
            q_entry.sep       = (text_byte == CH_SPACE) ? SEP_SPACE : SEP_NEWLINE;
            q_entry.pixels    = pix_eff;
            if (q_push)
            begin
                len_next = '0;
                pix_next = '0;
            end
        end
        else
        begin
            q_entry.has_glyph = 1'b1;
            q_entry.flush     = flush_word;
            q_entry.sep       = SEP_NONE;
            q_entry.pixels    = pix_new;
            if (q_push)
            begin
                len_next = flush_word ? '0 : len_new;
                pix_next = flush_word ? '0 : pix_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pix_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            pix_reg <= pix_next;
        end
    end

endmodule

@@ src/gww_back.sv @@
module gww_back #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gww_pkg::gww_cfg_t   cfg,
    input  logic                q_empty,
    input  gww_pkg::gww_entry_t q_entry,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          glyph_code,
    output logic [15:0]         pos_x,
    output logic [15:0]         pos_y,
    output logic                last_of_run
);
    import gww_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    back_state_t   state_reg, state_next;
    logic [15:0]   pen_x_reg, pen_x_next;
    logic [15:0]   pen_y_reg, pen_y_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [15:0]   pix_reg, pix_next;
    sep_t          sep_reg, sep_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_code_reg, out_code_next;
    logic [15:0]   out_x_reg, out_x_next;
    logic [15:0]   out_y_reg, out_y_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    word_mem [MAX_WORD];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic          slot_free;
    logic [15:0]   tx, ty;
    logic [16:0]   fit_sum;
    logic [LW-1:0] len_eff;
    logic          last_glyph;

    assign empty       = !out_valid_reg;
    assign glyph_code  = out_code_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign last_of_run = out_last_reg;
    assign slot_free   = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pix_next       = pix_reg;
        sep_next       = sep_reg;
        out_valid_next = out_valid_reg && !pop;
        out_code_next  = out_code_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        len_eff        = q_entry.restart ? '0 : len_reg;
        wr_addr        = len_eff[AW-1:0];
        rd_addr        = idx_reg;
        tx             = pen_x_reg;
        ty             = pen_y_reg;
        fit_sum        = {1'b0, pen_x_reg} + {1'b0, pix_reg};
        last_glyph     = (LW'(idx_reg) + LW'(1)) == len_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_entry.restart)
                    begin
                        pen_x_next = '0;
                        pen_y_next = '0;
                    end
                    if (q_entry.has_glyph)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_eff + LW'(1);
                    end
                    else
                    begin
                        len_next = len_eff;
                    end
                    if (q_entry.flush)
                    begin
                        pix_next   = q_entry.pixels;
                        sep_next   = q_entry.sep;
                        state_next = BK_TEST;
                    end
                end
            end
            BK_TEST:
            begin
                rd_addr  = '0;
                idx_next = '0;
                if ((pen_x_reg != 16'd0) && (fit_sum > {5'd0, cfg.line_width}))
                begin
                    tx = '0;
                    ty = pen_y_reg + {8'd0, cfg.line_advance};
                end
                if (len_reg == '0)
                begin
                    unique case (sep_reg)
                        SEP_SPACE:
                        begin
                            tx = tx + {8'd0, cfg.char_advance};
                        end
                        SEP_NEWLINE:
                        begin
                            tx = '0;
                            ty = ty + {8'd0, cfg.line_advance};
                        end
                        default:
                        begin
                            tx = tx;
                        end
                    endcase
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = BK_SEND;
                end
                pen_x_next = tx;
                pen_y_next = ty;
            end
            BK_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = rd_data_reg;
                    out_x_next     = pen_x_reg;
                    out_y_next     = pen_y_reg;
                    out_last_next  = last_glyph;
                    rd_addr        = idx_reg + AW'(1);
                    idx_next       = idx_reg + AW'(1);
                    tx = pen_x_reg + {8'd0, cfg.char_advance} + {8'd0, cfg.char_gap};
                    if (last_glyph)
                    begin
                        unique case (sep_reg)
                            SEP_SPACE:
                            begin
                                tx = tx + {8'd0, cfg.char_advance};
                            end
                            SEP_NEWLINE:
                            begin
                                tx = '0;
                                ty = pen_y_reg + {8'd0, cfg.line_advance};
                            end
                            default:
                            begin
                                tx = tx;
                            end
                        endcase
                        len_next   = '0;
                        state_next = BK_IDLE;
                    end
                    pen_x_next = tx;
                    pen_y_next = ty;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        sep_reg      <= sep_next;
        out_code_reg <= out_code_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_addr] <= q_entry.code;
        end
        rd_data_reg <= word_mem[rd_addr];
    end

endmodule

@@ src/gww_checker.sv @@
`include "greedy_word_wrap_text_layout_macros.svh"

module gww_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  glyph_code,
    input logic [15:0] pos_x,
    input logic [15:0] pos_y,
    input logic        last_of_run
);

    `GWW_ASSERT_NEXT(a_word_held, clk, rst_n, !empty && !pop, !empty && $stable(glyph_code) && $stable(pos_x) && $stable(pos_y) && $stable(last_of_run), "result word changed while stalled")
    `GWW_ASSERT_NEXT(a_run_follows, clk, rst_n, pop && !empty && !last_of_run, !empty, "gap inside a run of placements")
    `GWW_ASSERT_NEXT(a_run_same_row, clk, rst_n, pop && !empty && !last_of_run, pos_y == $past(pos_y), "line break inside a word")
    `GWW_ASSERT_NOW(a_reset_idle, clk, !rst_n, empty && !full, "ports not idle in reset")

endmodule

bind greedy_word_wrap_text_layout gww_checker u_checker (.*);

@@ sim/greedy_word_wrap_text_layout_test.sv @@
`timescale 1ns / 100ps

module greedy_word_wrap_text_layout_test;

    import gww_pkg::*;

    localparam int WORD_MAX     = MAX_WORD_DEF;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [7:0]  glyph;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } placement_t;

    typedef struct {
        logic [7:0]  code;
        logic        eot;
        logic        rs;
        bit          typed;
        logic [15:0] x;
        logic [15:0] y;
    } text_row_t;

    typedef struct {
        logic [7:0]  advance;
        logic [7:0]  gap;
        logic [7:0]  line_step;
        logic [11:0] width;
        int          send_pct;
        int          stall_pct;
        int          budget;
    } phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CHAR_ADVANCE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  text_byte = 8'd0;
    logic        end_of_text = 1'b0;
    logic        restart = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  glyph_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last_of_run;

    int send_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int chars_in = 0;
    int placements_seen = 0;
    int quiet_cycles = 0;

    // layout predictor state
    gww_cfg_t   lay_cfg;
    int         pen_col;
    int         pen_row;
    logic [7:0] word_bytes [WORD_MAX];
    int         word_len;
    int         word_width;
    placement_t placement_q [$];
    placement_t head;

    // directed text, reset settings: glyphs step 7 px, lines step 7 px
    text_row_t text_rows [17] = '{
        '{8'h41, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'h42, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_SPACE, 1'b0, 1'b0, 1'b1, 16'd7, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_NEWLINE, 1'b0, 1'b0, 1'b1, 16'd27, 16'd0},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'h43, 1'b1, 1'b0, 1'b1, 16'd6, 16'd7},
        '{CH_SPACE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'h44, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
        '{8'h45, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
        '{CH_NEWLINE, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0},
        '{8'h46, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'h47, 1'b1, 1'b0, 1'b1, 16'd7, 16'd7},
        '{CH_NEWLINE, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
        '{8'h48, 1'b1, 1'b0, 1'b1, 16'd0, 16'd7},
        '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}
    };

    phase_t plan [5] = '{
        '{8'd6,   8'd1,   8'd7,   12'd224,  0,  0,  12},
        '{8'd3,   8'd2,   8'd5,   12'd40,   54, 0,  12},
        '{8'd0,   8'd0,   8'd0,   12'd0,    0,  54, 10},
        '{8'd255, 8'd255, 8'd255, 12'd4095, 14, 14, 12},
        '{8'd8,   8'd3,   8'd11,  12'd1,    54, 0,  10}
    };

    greedy_word_wrap_text_layout u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .restart     (restart),
        .empty       (empty),
        .pop         (pop),
        .glyph_code  (glyph_code),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic void start_line();
        pen_col = 0;
        pen_row = (pen_row + lay_cfg.line_advance) & 16'hFFFF;
    endfunction

    function automatic void place_word();
        placement_t p;
        if (pen_col + word_width > lay_cfg.line_width && pen_col != 0)
        begin
            start_line();
        end
        for (int i = 0; i < word_len; i++)
        begin
            p.glyph = word_bytes[i];
            p.x = pen_col[15:0];
            p.y = pen_row[15:0];
            p.last = 1'b0;
            placement_q.push_back(p);
            pen_col = (pen_col + lay_cfg.char_advance + lay_cfg.char_gap) & 16'hFFFF;
        end
        word_len = 0;
        word_width = 0;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic eot, logic rs);
        int queued;
        placement_t p;
        queued = placement_q.size();
        if (rs)
        begin
            pen_col = 0;
            pen_row = 0;
            word_len = 0;
            word_width = 0;
        end
        if (c == CH_SPACE || c == CH_NEWLINE)
        begin
            place_word();
            if (c == CH_SPACE)
                pen_col = (pen_col + lay_cfg.char_advance) & 16'hFFFF;
            else
                start_line();
        end
        else
        begin
            if (word_len < WORD_MAX)
            begin
                if (word_len > 0)
                    word_width += lay_cfg.char_gap;
                word_width = (word_width + lay_cfg.char_advance) & 16'hFFFF;
                word_bytes[word_len] = c;
                word_len++;
            end
            if (word_len >= WORD_MAX || eot)
                place_word();
        end
        if (placement_q.size() > queued)
        begin
            p = placement_q.pop_back();
            p.last = 1'b1;
            placement_q.push_back(p);
        end
    endfunction

    function automatic logic [7:0] glyph_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_SPACE || c == CH_NEWLINE);
        return c;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_CHAR_ADVANCE: lay_cfg.char_advance = value[7:0];
            REG_CHAR_GAP:     lay_cfg.char_gap = value[7:0];
            REG_LINE_ADVANCE: lay_cfg.line_advance = value[7:0];
            REG_LINE_WIDTH:   lay_cfg.line_width = value[11:0];
            default: ;
        endcase
    endtask

    task automatic send_char(logic [7:0] c, logic eot, logic rs, bit typed = 1'b0,
                             logic [15:0] tx = 16'd0, logic [15:0] ty = 16'd0);
        int queued;
        placement_t p;
        while ($urandom_range(99) < send_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        text_byte   <= c;
        end_of_text <= eot;
        restart     <= rs;
        push        <= 1'b1;
        do
            @(posedge clk);
        while (full);
        chars_in++;
        queued = placement_q.size();
        predict_char(c, eot, rs);
        if (typed && placement_q.size() > queued)
        begin
            p = placement_q.pop_back();
            p.x = tx;
            p.y = ty;
            placement_q.push_back(p);
        end
    endtask

    // hold until every placement is back, then let the pipe run dry
    task automatic settle();
        push <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic play_text(int budget);
        int sent;
        int len;
        int i;
        bit eot_word;
        bit rs;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
                rs = ($urandom_range(19) == 0);
                eot_word = ($urandom_range(6) == 0);
                for (i = 0; i < len; i++)
                    send_char(glyph_byte(), eot_word && i == len - 1, rs && i == 0);
                if (!eot_word)
                    send_char(($urandom_range(2) == 0) ? CH_NEWLINE : CH_SPACE,
                              $urandom_range(9) == 0, 1'b0);
                sent += len + 1;
            end
            else
            begin
                send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                          $urandom_range(7) == 0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                placements_seen++;
                if (placement_q.size() == 0)
                begin
                    $error("unexpected placement: glyph_code %0d at %0d,%0d",
                           glyph_code, pos_x, pos_y);
                    mismatches++;
                end
                else
                begin
                    head = placement_q.pop_front();
                    compare_field("glyph_code", 16'(head.glyph), 16'(glyph_code));
                    compare_field("pos_x", head.x, pos_x);
                    compare_field("pos_y", head.y, pos_y);
                    compare_field("last_of_run", 16'(head.last), 16'(last_of_run));
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        lay_cfg.char_advance = RST_CHAR_ADVANCE;
        lay_cfg.char_gap     = RST_CHAR_GAP;
        lay_cfg.line_advance = RST_LINE_ADVANCE;
        lay_cfg.line_width   = RST_LINE_WIDTH;
        pen_col    = 0;
        pen_row    = 0;
        word_len   = 0;
        word_width = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (text_rows[r])
            send_char(text_rows[r].code, text_rows[r].eot, text_rows[r].rs,
                      text_rows[r].typed, text_rows[r].x, text_rows[r].y);
        settle();

        foreach (plan[k])
        begin
            write_reg(REG_CHAR_ADVANCE, CFG_DATA_W'(plan[k].advance));
            write_reg(REG_CHAR_GAP, CFG_DATA_W'(plan[k].gap));
            write_reg(REG_LINE_ADVANCE, CFG_DATA_W'(plan[k].line_step));
            write_reg(REG_LINE_WIDTH, plan[k].width);
            cfg_wr_en <= 1'b0;
            send_pct  <= plan[k].send_pct;
            stall_pct <= plan[k].stall_pct;
            @(posedge clk);
            play_text(plan[k].budget);
            settle();
        end

        $display("text layout: %0d characters in, %0d placements checked", chars_in,
                 placements_seen);
        $display("five register settings incl. all-zero and all-max, four idle/stall mixes");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/gww_pkg.sv
src/gww_queue.sv
src/gww_front.sv
src/gww_back.sv
src/greedy_word_wrap_text_layout.sv
src/gww_checker.sv
sim/greedy_word_wrap_text_layout_test.sv
